// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers for the text console; NO_ASSERTIONS drops them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset
`define TCPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define TCPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCPS_ASSERT(lbl, prop, msg)
`define TCPS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/tcps_pkg.sv =====
// ---------------------------------------------------------------------------
// tcps_pkg
// Shared types and constants of the text console engine.
// ---------------------------------------------------------------------------
`default_nettype none

package tcps_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int COPY_N = (ROWS - 1) * COLS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int LIN_W  = ADDR_W + 1;
  localparam int CELL_W = 16;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int HW_W   = 11;
  localparam int CFG_AW = 3;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]        NEWLINE    = 8'h0A;
  localparam logic [7:0]        ATTR_RESET = 8'h0F;

  // register index, taken from paddr[2]
  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_SET_CUR = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [7:0]       ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [HW_W-1:0]  hw_cursor;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } out_item_t;

  typedef struct packed {
    logic latch_req;
    logic put;
    logic scroll_start;
    logic sweep_step;
    logic sweep_copy;
    logic set_cur;
    logic rd_cell;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic sweep_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcps_ram.sv =====
// ---------------------------------------------------------------------------
// tcps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module tcps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcps_dp.sv =====
// ---------------------------------------------------------------------------
// tcps_dp
// Datapath: cursor registers, screen store, sweep counter and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcps_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tcps_pkg::in_item_t  in_data,
  input  wire logic [7:0]          text_attr,
  input  wire tcps_pkg::dp_cmd_t   cmd,
  output tcps_pkg::dp_sts_t        sts,
  output tcps_pkg::out_item_t      out_data
);

  import tcps_pkg::*;

  in_item_t          req_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [HW_W-1:0]   hw_r, hw_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic              pend_v_r;
  logic              pend_copy_r;
  logic [ADDR_W-1:0] pend_addr_r;
  out_item_t         out_r;

  logic              wrap;
  logic [ROW_W-1:0]  row_w;
  logic [COL_W-1:0]  col_w;
  logic [LIN_W-1:0]  put_lin;
  logic [LIN_W-1:0]  rd_lin;
  logic [LIN_W-1:0]  src_lin;
  logic              is_nl;
  logic              put_we;
  logic              rd_ok;
  logic              copy_rd;
  logic              sweep_last;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // resolve a pending wrap before the put
  assign wrap    = (col_r >= COL_W'(COLS));
  assign row_w   = wrap ? row_r + ROW_W'(1) : row_r;
  assign col_w   = wrap ? '0 : col_r;
  assign put_lin = LIN_W'(row_w) * LIN_W'(COLS) + LIN_W'(col_w);
  assign is_nl   = (req_r.ch == NEWLINE);
  assign put_we  = cmd.put && !is_nl;

  assign rd_ok   = (req_r.row < ROW_W'(ROWS)) && (req_r.col < COL_W'(COLS));
  assign rd_lin  = LIN_W'(req_r.row) * LIN_W'(COLS) + LIN_W'(req_r.col);

  // scroll copies cell i+COLS down to i, one cell a cycle
  assign copy_rd    = cmd.sweep_copy && (cnt_r < ADDR_W'(COPY_N));
  assign src_lin    = LIN_W'(cnt_r) + LIN_W'(COLS);
  assign sweep_last = (cnt_r == ADDR_W'(CELLS - 1));

  assign sts.need_scroll = (row_w >= ROW_W'(ROWS));
  assign sts.sweep_last  = sweep_last;

  // pending sweep write owns the port; the controller never overlaps a put
  assign ram_we    = pend_v_r || put_we;
  assign ram_waddr = pend_v_r ? pend_addr_r : ADDR_W'(put_lin);
  assign ram_wdata = pend_v_r ? (pend_copy_r ? ram_rdata : BLANK_CELL)
                              : {text_attr, req_r.ch};
  assign ram_re    = (cmd.sweep_step && copy_rd) || (cmd.rd_cell && rd_ok);
  assign ram_raddr = cmd.rd_cell ? ADDR_W'(rd_lin) : ADDR_W'(src_lin);

  tcps_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    hw_nxt  = hw_r;
    if (cmd.scroll_start) begin
      row_nxt = ROW_W'(ROWS - 1);
      col_nxt = '0;
    end else if (cmd.put) begin
      if (is_nl) begin
        row_nxt = row_w + ROW_W'(1);
        col_nxt = '0;
      end else begin
        row_nxt = row_w;
        col_nxt = col_w + COL_W'(1);
        hw_nxt  = HW_W'(put_lin + LIN_W'(1));
      end
    end else if (cmd.set_cur) begin
      row_nxt = (req_r.row >= ROW_W'(ROWS)) ? ROW_W'(ROWS - 1) : req_r.row;
      col_nxt = (req_r.col >= COL_W'(COLS)) ? COL_W'(COLS - 1) : req_r.col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      hw_r     <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      hw_r     <= hw_nxt;
      pend_v_r <= cmd.sweep_step;
      if (cmd.sweep_step) begin
        cnt_r <= sweep_last ? '0 : cnt_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      pend_addr_r <= cnt_r;
      pend_copy_r <= copy_rd;
    end
    if (cmd.latch_req) begin
      req_r <= in_data;
    end
    if (cmd.load_out) begin
      out_r.cursor_row <= row_r;
      out_r.cursor_col <= col_r;
      out_r.hw_cursor  <= hw_r;
      if ((req_r.cmd == CMD_READ) && rd_ok) begin
        out_r.cell_char <= ram_rdata[7:0];
        out_r.cell_attr <= ram_rdata[15:8];
      end else begin
        out_r.cell_char <= '0;
        out_r.cell_attr <= '0;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcps_ctrl.sv =====
// ---------------------------------------------------------------------------
// tcps_ctrl
// Controller: sequences put, scroll, clear and read, and owns the handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module tcps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire tcps_pkg::cmd_t    in_cmd,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire tcps_pkg::dp_sts_t sts,
  output tcps_pkg::dp_cmd_t      cmd
);

  import tcps_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_SCROLL_TAIL,
    ST_SET_CUR,
    ST_CLEAR,
    ST_READ,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          case (in_cmd)
            CMD_PUT:     state_nxt = ST_PUT;
            CMD_SET_CUR: state_nxt = ST_SET_CUR;
            CMD_CLEAR:   state_nxt = ST_CLEAR;
            CMD_READ:    state_nxt = ST_READ;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PUT: begin
        if (sts.need_scroll) begin
          cmd.scroll_start = 1'b1;
          state_nxt        = ST_SCROLL;
        end else begin
          cmd.put   = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_SCROLL: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_copy = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_SCROLL_TAIL;
        end
      end
      // let the last sweep write land before the put
      ST_SCROLL_TAIL: state_nxt = ST_PUT;
      ST_SET_CUR: begin
        cmd.set_cur = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.rd_cell = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/text_console_put_scroll.sv =====
// Put-char, set-cursor and read-cell: one request at a time; in_stall stays high while
// the controller walks its decode/execute/finish steps, and finish holds on out_stall.
// A put that scrolls first sweeps the screen, one cell a cycle over the RAM ports,
// then passes a tail state. Clear sweeps every cell to blank. After reset the screen
// is blanked in a clearing pass with in_stall high; register writes still land.
// Synchronous active-low reset; text_attr resets to 15, cursors to 0.
// ---------------------------------------------------------------------------
// text_console_put_scroll
// 80x25 text console engine with wrap, scroll, clear and cell read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module text_console_put_scroll (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire tcps_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output tcps_pkg::out_item_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcps_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import tcps_pkg::*;

  logic [7:0] attr_r;
  logic       cfg_wr;
  dp_cmd_t    dp_cmd;
  dp_sts_t    dp_sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'b0, attr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_wr && (paddr[2] == REG_TEXT_ATTR)) begin
      attr_r <= pwdata[7:0];
    end
  end

  tcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  tcps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .text_attr (attr_r),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_data  (out_data)
  );

  `TCPS_ASSERT_ALWAYS(a_rst_no_result, !rst_n |=> !out_valid, "result valid right after reset")
  `TCPS_ASSERT(a_one_at_a_time, (in_valid && !in_stall) |=> in_stall, "request taken while busy")
  `TCPS_ASSERT(a_cursor_range, out_valid |-> (out_data.cursor_col <= COL_W'(COLS)) && (out_data.cursor_row <= ROW_W'(ROWS)), "cursor out of range")
  `TCPS_ASSERT(a_hw_range, out_valid |-> (out_data.hw_cursor <= HW_W'(CELLS)), "hw cursor out of range")

endmodule

`default_nettype wire
